/* hw/rtl/bta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants of the block table allocator
// Field widths, flag bit positions, status codes and the sequencer states.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned BytesW = 23;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FlagW  = 3;

  // flag bits of one table entry
  localparam int unsigned FlagStart  = 0;
  localparam int unsigned FlagNext   = 1;
  localparam int unsigned FlagLocked = 2;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_BADARG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MARK,
    S_FWALK,
    S_RESP
  } state_e;

endpackage

/* hw/rtl/block_table_heap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_table_heap_allocator: first-fit allocator over a block flag table
// One memory of per-block flags (start, next, locked) walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel (tuser = opcode, 0 allocate, 1 free;
//   tdata = request_bytes, address). Each request gives exactly one response
//   on m_axis (tuser = status, tdata = result address, 0 unless allocate ok).
//   The user writes heap_base on the cfg channel only while the block is idle;
//   the block does not enforce it. One request is in flight at a time:
//   s_axis_tready_o is low from accept until the response has been taken.
//   The sequencer walks the flag memory one entry per cycle:
//     allocate: scans entries (up to TABLE_ENTRIES) for a free run, then marks
//       the blocks of that run; rejected sizes are answered from decode.
//     free: clears the blocks of the run; rejects come from decode or the walk.
//   After reset the flag table is cleared one entry per cycle, so requests
//   are refused until the clear is done; cfg writes are taken at any time.
//   While the receiver holds m_axis_tready_i low the response stays put and
//   no new request is taken.
// ----------------------------------------------------------------------------
module block_table_heap_allocator
  import bta_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024,  // 2 .. 65536
  parameter int unsigned BLOCK_BYTES   = 4096   // power of two, 16 .. 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: heap_base
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [AddrW-1:0]     cfg_data_i,
  // requests
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [71:0]          s_axis_tdata_i,   // [22:0] request_bytes, [70:23] address
  input  logic [0:0]           s_axis_tuser_i,   // [0] opcode
  // responses
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [AddrW-1:0]     m_axis_tdata_o,   // [47:0] result_address
  output logic [StatW-1:0]     m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned Sh   = $clog2(BLOCK_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [CntW-1:0] NumEnt  = CntW'(TABLE_ENTRIES);

  state_e state_q, state_d;

  logic [AddrW-1:0]  heap_base_q;
  logic              op_q;
  logic [BytesW-1:0] bytes_q;
  logic [AddrW-1:0]  addr_q;

  logic [CntW-1:0]   blocks_q, blocks_d;
  logic [CntW-1:0]   ptr_q, ptr_d;      // next entry to read in the scan
  logic [CntW-1:0]   run_q, run_d;
  logic [CntW-1:0]   left_q, left_d;
  logic [IdxW-1:0]   wptr_q, wptr_d;
  logic [IdxW-1:0]   first_q, first_d;
  logic              frst_q, frst_d;
  logic              rvld_q, rvld_d;
  logic [IdxW-1:0]   rd_idx_q;

  status_e           status_q, status_d;
  logic [AddrW-1:0]  res_q, res_d;

  // flag memory
  logic [FlagW-1:0]  mem [TABLE_ENTRIES];
  logic [FlagW-1:0]  rd_data_q;
  logic [IdxW-1:0]   raddr;
  logic              mem_we;
  logic [IdxW-1:0]   waddr;
  logic [FlagW-1:0]  wdata;

  // decode arithmetic
  logic [BytesW:0]   bytes_rnd;
  logic [BytesW:0]   blocks_full;
  logic [AddrW:0]    diff;
  logic              f_bad;
  logic [IdxW-1:0]   f_idx;
  logic [CntW-1:0]   run_new;
  logic [CntW-1:0]   found_first;

  always_comb begin
    bytes_rnd   = {1'b0, bytes_q} + (BytesW + 1)'(BLOCK_BYTES - 1);
    blocks_full = bytes_rnd >> Sh;
    diff        = {1'b0, addr_q} - {1'b0, heap_base_q};
    f_bad       = diff[AddrW] || (diff[Sh-1:0] != '0) ||
                  (64'(diff[AddrW-1:Sh]) >= 64'(TABLE_ENTRIES));
    f_idx       = diff[Sh+IdxW-1:Sh];
    run_new     = rd_data_q[FlagLocked] ? '0 : run_q + CntW'(1);
    found_first = CntW'(rd_idx_q) + CntW'(1) - blocks_q;
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_RESP);
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = status_q;

  always_comb begin
    state_d  = state_q;
    blocks_d = blocks_q;
    ptr_d    = ptr_q;
    run_d    = run_q;
    left_d   = left_q;
    wptr_d   = wptr_q;
    first_d  = first_q;
    frst_d   = frst_q;
    status_d = status_q;
    res_d    = res_q;
    rvld_d   = 1'b0;
    raddr    = ptr_q[IdxW-1:0];
    mem_we   = 1'b0;
    waddr    = wptr_q;
    wdata    = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        wptr_d = wptr_q + IdxW'(1);
        if (wptr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_d = '0;
        if (op_q == OP_ALLOC) begin
          blocks_d = CntW'(blocks_full);
          ptr_d    = '0;
          run_d    = '0;
          if (bytes_q == '0) begin
            status_d = ST_BADARG;
            state_d  = S_RESP;
          end else if (32'(blocks_full) > 32'(TABLE_ENTRIES)) begin
            status_d = ST_NOMEM;
            state_d  = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end else begin
          if (f_bad) begin
            status_d = ST_BADARG;
            state_d  = S_RESP;
          end else begin
            raddr   = f_idx;
            wptr_d  = f_idx;
            frst_d  = 1'b1;
            state_d = S_FWALK;
          end
        end
      end

      S_SCAN: begin
        // reads run one entry ahead of the run check
        raddr = ptr_q[IdxW-1:0];
        if (ptr_q != NumEnt) begin
          rvld_d = 1'b1;
          ptr_d  = ptr_q + CntW'(1);
        end
        if (rvld_q) begin
          run_d = run_new;
          if (run_new == blocks_q) begin
            first_d = found_first[IdxW-1:0];
            wptr_d  = found_first[IdxW-1:0];
            left_d  = blocks_q;
            rvld_d  = 1'b0;
            state_d = S_MARK;
          end else if (rd_idx_q == LastIdx) begin
            status_d = ST_NOMEM;
            rvld_d   = 1'b0;
            state_d  = S_RESP;
          end
        end
      end

      S_MARK: begin
        mem_we = 1'b1;
        wdata[FlagLocked] = 1'b1;
        wdata[FlagStart]  = (wptr_q == first_q);
        wdata[FlagNext]   = (left_q != CntW'(1));
        wptr_d = wptr_q + IdxW'(1);
        left_d = left_q - CntW'(1);
        if (left_q == CntW'(1)) begin
          status_d = ST_OK;
          res_d    = heap_base_q + (AddrW'(first_q) << Sh);
          state_d  = S_RESP;
        end
      end

      S_FWALK: begin
        // rd_data_q holds the flags of wptr_q; fetch the following entry
        raddr = wptr_q + IdxW'(1);
        if (frst_q && !rd_data_q[FlagStart]) begin
          status_d = ST_BADARG;
          state_d  = S_RESP;
        end else begin
          mem_we = 1'b1;
          frst_d = 1'b0;
          wptr_d = wptr_q + IdxW'(1);
          if (!rd_data_q[FlagNext] || wptr_q == LastIdx) begin
            status_d = ST_OK;
            state_d  = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      heap_base_q <= '0;
      wptr_q      <= '0;
      rvld_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      rvld_q  <= rvld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        heap_base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q    <= s_axis_tuser_i[0];
      bytes_q <= s_axis_tdata_i[BytesW-1:0];
      addr_q  <= s_axis_tdata_i[BytesW+AddrW-1:BytesW];
    end
    blocks_q <= blocks_d;
    ptr_q    <= ptr_d;
    run_q    <= run_d;
    left_q   <= left_d;
    first_q  <= first_d;
    frst_q   <= frst_d;
    status_q <= status_d;
    res_q    <= res_d;
    rd_idx_q <= raddr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[raddr];
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: block table heap allocator
// Drives allocate and free requests over the request stream, changes
// heap_base between phases and compares every response with a first-fit
// model of the flag table kept inside the bench.
// ----------------------------------------------------------------------------
module testbench
  import bta_pkg::*;
();

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned BLOCK_BYTES   = 4096;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int unsigned TAIL_CYCLES   = 2 * TABLE_ENTRIES + 16;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] addr;
  } heap_response_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic             cfg_valid = 1'b0;
  logic [AddrW-1:0] cfg_data  = '0;
  logic             s_valid   = 1'b0;
  logic [71:0]      s_tdata   = '0;
  logic [0:0]       s_tuser   = '0;
  logic             m_ready   = 1'b0;
  logic             no_idle   = 1'b0;

  logic             cfg_ready_o;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [AddrW-1:0] m_axis_tdata_o;
  logic [StatW-1:0] m_axis_tuser_o;

  // model state
  logic [FlagW-1:0] flag_table [TABLE_ENTRIES];
  logic [AddrW-1:0] heap_base_model = '0;
  int unsigned      live_runs [$];   // first block index of every allocated run
  heap_response_t   pending_responses [$];
  heap_response_t   oldest;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  block_table_heap_allocator #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .BLOCK_BYTES  (BLOCK_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),    // [22:0] request_bytes, [70:23] address
    .s_axis_tuser_i (s_tuser),    // [0] opcode
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),  // [47:0] result_address
    .m_axis_tuser_o (m_axis_tuser_o)   // [1:0] status
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_ready <= no_idle || ($urandom_range(99) >= 16);
  end

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_responses.size() == 0) begin
        $error("status: expected no response, got %0d (result_address %h)",
               m_axis_tuser_o, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        oldest = pending_responses.pop_front();
        if (m_axis_tuser_o !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o !== oldest.addr) begin
          $error("result_address: expected %h, got %h", oldest.addr, m_axis_tdata_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [AddrW-1:0] block_addr(input longint unsigned idx);
    return heap_base_model + AddrW'(idx * BLOCK_BYTES);
  endfunction

  // First-fit allocate / run-walk free on the model table.
  function automatic heap_response_t predict_heap_op(input op_e op,
                                                    input logic [BytesW-1:0] nbytes,
                                                    input logic [AddrW-1:0] addr);
    heap_response_t   rsp;
    longint unsigned  blocks, run, first, offset, idx, i, k;
    logic [FlagW-1:0] flags;
    bit               last;
    int               hit;
    rsp.status = ST_OK;
    rsp.addr   = '0;
    if (op == OP_ALLOC) begin
      blocks = (longint'(nbytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (nbytes == 0) begin
        rsp.status = ST_BADARG;
      end else if (blocks > TABLE_ENTRIES) begin
        rsp.status = ST_NOMEM;
      end else begin
        rsp.status = ST_NOMEM;
        run = 0;
        for (i = 0; i < TABLE_ENTRIES && rsp.status != ST_OK; i++) begin
          run = flag_table[i][FlagLocked] ? 0 : run + 1;
          if (run == blocks) begin
            first = i + 1 - run;
            for (k = 0; k < blocks; k++) begin
              flags = '0;
              flags[FlagLocked] = 1'b1;
              flags[FlagStart]  = (k == 0);
              flags[FlagNext]   = (k + 1 != blocks);
              flag_table[first + k] = flags;
            end
            rsp.status = ST_OK;
            rsp.addr   = block_addr(first);
            live_runs.push_back(int'(first));
          end
        end
      end
    end else begin
      offset = longint'(addr - heap_base_model);
      idx    = offset / BLOCK_BYTES;
      if (addr < heap_base_model || offset % BLOCK_BYTES != 0 ||
          idx >= TABLE_ENTRIES) begin
        rsp.status = ST_BADARG;
      end else if (!flag_table[idx][FlagStart]) begin
        rsp.status = ST_BADARG;
      end else begin
        first = idx;
        last  = 1'b0;
        while (idx < TABLE_ENTRIES && !last) begin
          last = !flag_table[idx][FlagNext];
          flag_table[idx] = '0;
          idx++;
        end
        hit = -1;
        foreach (live_runs[j]) if (live_runs[j] == first) hit = j;
        if (hit >= 0) live_runs.delete(hit);
      end
    end
    return rsp;
  endfunction

  task automatic send_request(input op_e op, input logic [BytesW-1:0] nbytes,
                              input logic [AddrW-1:0] addr);
    while (!no_idle && $urandom_range(99) < 16) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {1'b0, addr, nbytes};
    s_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_responses.push_back(predict_heap_op(op, nbytes, addr));
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_responses.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_heap_base(input logic [AddrW-1:0] base);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    heap_base_model = base;
  endtask

  task automatic test_directed_cases();
    wait_idle();
    write_heap_base(48'h0001_2345_6000);
    send_request(OP_ALLOC, 0, '0);                           // zero size
    send_request(OP_ALLOC, BytesW'(TABLE_ENTRIES * BLOCK_BYTES + 1), '0); // larger than table
    send_request(OP_ALLOC, '1, '1);
    send_request(OP_ALLOC, BytesW'(TABLE_ENTRIES * BLOCK_BYTES), '0); // whole table
    send_request(OP_ALLOC, 1, '0);                           // table full
    send_request(OP_FREE, '1, block_addr(1));                // no start flag
    send_request(OP_FREE, 0, block_addr(0));
    send_request(OP_ALLOC, 1, '0);
    send_request(OP_ALLOC, BytesW'(BLOCK_BYTES), '0);
    send_request(OP_ALLOC, BytesW'(BLOCK_BYTES + 1), '0);
    send_request(OP_FREE, 0, block_addr(0) + 1);             // misaligned
    send_request(OP_FREE, 0, '0);                            // below base
    send_request(OP_FREE, 0, block_addr(TABLE_ENTRIES));     // past the table
    send_request(OP_FREE, 0, block_addr(1));
    send_request(OP_FREE, 0, block_addr(1));                 // double free
    send_request(OP_ALLOC, BytesW'(2 * BLOCK_BYTES), '0);    // skips the one-block hole
    send_request(OP_ALLOC, 1, '0);                           // fills the hole
    send_request(OP_FREE, 0, block_addr(2));
    send_request(OP_FREE, 0, block_addr(3));
    send_request(OP_FREE, 0, '1);
  endtask

  // Top-of-space base: later blocks wrap past zero and can no longer be freed.
  task automatic test_base_extremes();
    wait_idle();
    write_heap_base(48'hFFFF_FFFF_F000);
    send_request(OP_ALLOC, 1, '0);
    send_request(OP_ALLOC, BytesW'(2 * BLOCK_BYTES), '0);
    send_request(OP_FREE, 0, block_addr(0));
    send_request(OP_FREE, 0, block_addr(2));
    wait_idle();
    write_heap_base('0);
    send_request(OP_FREE, 0, block_addr(2));
    send_request(OP_ALLOC, 1, '0);
  endtask

  task automatic test_random_traffic(input int unsigned count,
                                     input logic [AddrW-1:0] base, input bit steady);
    int unsigned       pick, idx;
    logic [BytesW-1:0] size_bytes, junk_bytes;
    logic [AddrW-1:0]  addr;
    wait_idle();
    write_heap_base(base);
    no_idle <= steady;
    repeat (count) begin
      pick       = $urandom_range(99);
      junk_bytes = BytesW'($urandom);
      addr       = AddrW'({$urandom, $urandom});
      if (pick < 45 || (pick < 82 && live_runs.size() == 0)) begin
        pick = $urandom_range(99);
        if (pick < 70)
          size_bytes = BytesW'($urandom_range(4 * BLOCK_BYTES, 1));
        else if (pick < 85)
          size_bytes = BytesW'($urandom_range(64 * BLOCK_BYTES, 4 * BLOCK_BYTES + 1));
        else if (pick < 92)
          size_bytes = BytesW'($urandom_range(TABLE_ENTRIES * BLOCK_BYTES,
                                              64 * BLOCK_BYTES + 1));
        else if (pick < 97)
          size_bytes = BytesW'($urandom);
        else
          size_bytes = BytesW'(TABLE_ENTRIES * BLOCK_BYTES + $urandom_range(1) - 1 +
                               ($urandom_range(1) ? 1 : 0));
        send_request(OP_ALLOC, size_bytes, addr);
      end else if (pick < 82) begin
        idx = live_runs[$urandom_range(live_runs.size() - 1)];
        send_request(OP_FREE, junk_bytes, block_addr(idx));
      end else begin
        case ($urandom_range(4))
          0: addr = block_addr($urandom_range(TABLE_ENTRIES - 1));
          1: addr = block_addr($urandom_range(TABLE_ENTRIES - 1)) +
                    AddrW'($urandom_range(BLOCK_BYTES - 1, 1));
          2: ;
          3: addr = heap_base_model - AddrW'($urandom_range(65536, 1));
          default: addr = block_addr(TABLE_ENTRIES + $urandom_range(4095));
        endcase
        send_request(OP_FREE, junk_bytes, addr);
      end
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    foreach (flag_table[i]) flag_table[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_base_extremes();
    test_random_traffic(200, AddrW'({$urandom, $urandom}) & ~AddrW'(BLOCK_BYTES - 1), 1'b0);
    test_random_traffic(120, AddrW'({$urandom, $urandom}) | AddrW'(1), 1'b0);
    test_random_traffic(100, '0, 1'b1);   // back to back, no stalls
    test_random_traffic(160, AddrW'({$urandom, $urandom}) & ~AddrW'(BLOCK_BYTES - 1), 1'b0);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
